// File: hdl/cart_pkg.sv
// Shared types and constants for the command acknowledge and retry tracker.
`timescale 1ns / 1ps
`default_nettype none
package cart_pkg;

	typedef enum logic [1:0] {
		FN_ISSUE  = 2'd0,
		FN_ACK    = 2'd1,
		FN_TICK   = 2'd2,
		FN_CANCEL = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		EV_NONE      = 4'd0,
		EV_SENT      = 4'd1,
		EV_REFUSED   = 4'd2,
		EV_RESENT    = 4'd3,
		EV_TIMEOUT   = 4'd4,
		EV_ACCEPTED  = 4'd5,
		EV_REJECTED  = 4'd6,
		EV_PROGRESS  = 4'd7,
		EV_WRONG     = 4'd8,
		EV_DUPLICATE = 4'd9,
		EV_LATE      = 4'd10,
		EV_IGNORED   = 4'd11,
		EV_CANCELLED = 4'd12
	} event_t;

	localparam logic [2:0] CFG_OWN_SYSTEM     = 3'd0;
	localparam logic [2:0] CFG_OWN_COMPONENT  = 3'd1;
	localparam logic [2:0] CFG_PEER_SYSTEM    = 3'd2;
	localparam logic [2:0] CFG_PEER_COMPONENT = 3'd3;
	localparam logic [2:0] CFG_TIMEOUT_MS     = 3'd4;
	localparam logic [2:0] CFG_RETRY_LIMIT    = 3'd5;
	localparam logic [2:0] CFG_REPEAT_GUARD   = 3'd6;

	localparam logic [7:0]  RST_OWN_SYSTEM     = 8'd245;
	localparam logic [7:0]  RST_OWN_COMPONENT  = 8'd191;
	localparam logic [7:0]  RST_PEER_SYSTEM    = 8'd1;
	localparam logic [7:0]  RST_PEER_COMPONENT = 8'd1;
	localparam logic [15:0] RST_TIMEOUT_MS     = 16'd1000;
	localparam logic [3:0]  RST_RETRY_LIMIT    = 4'd3;
	localparam logic [15:0] RST_REPEAT_GUARD   = 16'd15000;

	localparam logic [7:0]  ACK_ACCEPTED    = 8'd0;
	localparam logic [7:0]  ACK_IN_PROGRESS = 8'd5;
	localparam logic [15:0] CMD_SET_MSG_INTERVAL = 16'd511;

	typedef struct packed {
		func_t       func;
		logic [31:0] now_ms;
		logic [15:0] command;
		logic [31:0] param1;
		logic [7:0]  ack_result;
		logic [7:0]  src_system;
		logic [7:0]  src_component;
		logic [7:0]  tgt_system;
		logic [7:0]  tgt_component;
		logic        link_ok;
		logic        queue_room;
	} item_t;

	typedef struct packed {
		event_t      event_res;
		logic        send_valid;
		logic [15:0] send_command;
		logic [31:0] send_param1;
		logic [3:0]  retry_count;
		logic        pending_flag;
		logic        rejected_flag;
		logic        timed_out_flag;
		logic [15:0] last_ack_cmd;
		logic [7:0]  last_ack_code;
	} result_t;

endpackage
`default_nettype wire

// File: hdl/command_ack_retry_tracker.sv
// Top level of the command acknowledge and retry tracker.
//
//  channel  | direction | handshake                    | payload
//  item     | in        | item_valid / item_stall      | item_t
//  res      | out       | res_valid / res_stall        | result_t
//  cfg      | in        | cfg_we (no wait)             | cfg_index, cfg_data
//
// One word per cycle unless res stalls; a word goes from the input register to res.
// The tracker state updates as a word leaves the input register, so the next word
// sees it in the following cycle. Reset clears all tracker state and loads the
// register defaults. A stalled result holds the input register, which then stalls item.
`timescale 1ns / 1ps
`default_nettype none
module command_ack_retry_tracker
	import cart_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	output logic             res_valid,
	input  wire logic        res_stall,
	output result_t          res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [7:0]  own_system_q, own_component_q, peer_system_q, peer_component_q;
	logic [15:0] timeout_ms_q, repeat_guard_q;
	logic [3:0]  retry_limit_q;

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	logic        res_valid_q;
	result_t     res_q;

	logic        pending_q;
	logic [15:0] pending_cmd_q;
	logic [31:0] pending_p1_q;
	logic [31:0] deadline_q;
	logic [3:0]  retries_q;
	logic [15:0] done_cmd_q;
	logic [31:0] done_p1_q;
	logic [31:0] done_time_q;
	logic [15:0] expired_cmd_q;
	logic [15:0] ack_cmd_q;
	logic [7:0]  ack_code_q;
	logic        reject_q;
	logic        timeout_q;

	logic        pending_d;
	logic [15:0] pending_cmd_d;
	logic [31:0] pending_p1_d;
	logic [31:0] deadline_d;
	logic [3:0]  retries_d;
	logic [15:0] done_cmd_d;
	logic [31:0] done_p1_d;
	logic [31:0] done_time_d;
	logic [15:0] expired_cmd_d;
	logic [15:0] ack_cmd_d;
	logic [7:0]  ack_code_d;
	logic        reject_d;
	logic        timeout_d;
	result_t     res_d;

	logic [32:0] due_sum;
	logic [31:0] due_time;
	logic [31:0] since_done;
	logic        guarded;
	logic        ids_ok;

	assign advance    = valid_s1 && !(res_valid_q && res_stall);
	assign item_stall = valid_s1 && !advance;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_system_q     <= RST_OWN_SYSTEM;
			own_component_q  <= RST_OWN_COMPONENT;
			peer_system_q    <= RST_PEER_SYSTEM;
			peer_component_q <= RST_PEER_COMPONENT;
			timeout_ms_q     <= RST_TIMEOUT_MS;
			retry_limit_q    <= RST_RETRY_LIMIT;
			repeat_guard_q   <= RST_REPEAT_GUARD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_SYSTEM:     own_system_q     <= cfg_data[7:0];
				CFG_OWN_COMPONENT:  own_component_q  <= cfg_data[7:0];
				CFG_PEER_SYSTEM:    peer_system_q    <= cfg_data[7:0];
				CFG_PEER_COMPONENT: peer_component_q <= cfg_data[7:0];
				CFG_TIMEOUT_MS:     timeout_ms_q     <= cfg_data;
				CFG_RETRY_LIMIT:    retry_limit_q    <= cfg_data[3:0];
				CFG_REPEAT_GUARD:   repeat_guard_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// saturating deadline and repeat guard window
	assign due_sum    = {1'b0, item_s1.now_ms} + {17'd0, timeout_ms_q};
	assign due_time   = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
	assign since_done = item_s1.now_ms - done_time_q;
	assign guarded    = (done_cmd_q == item_s1.command) && (done_p1_q == item_s1.param1) &&
		(ack_code_q == ACK_ACCEPTED) && (item_s1.now_ms >= done_time_q) &&
		(since_done < {16'd0, repeat_guard_q});
	assign ids_ok     = (item_s1.src_system == peer_system_q) &&
		(item_s1.src_component == peer_component_q) &&
		((item_s1.tgt_system == 8'd0) || (item_s1.tgt_system == own_system_q)) &&
		((item_s1.tgt_component == 8'd0) || (item_s1.tgt_component == own_component_q));

	always_comb begin
		pending_d     = pending_q;
		pending_cmd_d = pending_cmd_q;
		pending_p1_d  = pending_p1_q;
		deadline_d    = deadline_q;
		retries_d     = retries_q;
		done_cmd_d    = done_cmd_q;
		done_p1_d     = done_p1_q;
		done_time_d   = done_time_q;
		expired_cmd_d = expired_cmd_q;
		ack_cmd_d     = ack_cmd_q;
		ack_code_d    = ack_code_q;
		reject_d      = reject_q;
		timeout_d     = timeout_q;
		res_d         = '0;
		res_d.event_res = EV_NONE;

		case (item_s1.func)
			FN_ISSUE: begin
				if (!item_s1.link_ok || pending_q || guarded || !item_s1.queue_room) begin
					res_d.event_res = EV_REFUSED;
				end else begin
					pending_d     = 1'b1;
					pending_cmd_d = item_s1.command;
					pending_p1_d  = item_s1.param1;
					deadline_d    = due_time;
					retries_d     = 4'd0;
					timeout_d     = 1'b0;
					reject_d      = 1'b0;
					res_d.send_valid   = 1'b1;
					res_d.send_command = item_s1.command;
					res_d.send_param1  = item_s1.param1;
					res_d.event_res    = EV_SENT;
				end
			end
			FN_ACK: begin
				if (!ids_ok) begin
					res_d.event_res = EV_WRONG;
				end else begin
					ack_cmd_d  = item_s1.command;
					ack_code_d = item_s1.ack_result;
					if (!pending_q) begin
						if (item_s1.command == CMD_SET_MSG_INTERVAL) begin
							res_d.event_res = EV_IGNORED;
						end else if (item_s1.command == done_cmd_q) begin
							res_d.event_res = EV_DUPLICATE;
						end else if (item_s1.command == expired_cmd_q) begin
							res_d.event_res = EV_LATE;
						end else begin
							res_d.event_res = EV_WRONG;
						end
					end else if (item_s1.command != pending_cmd_q) begin
						res_d.event_res = EV_WRONG;
					end else if (item_s1.ack_result == ACK_IN_PROGRESS) begin
						// push the deadline out while the peer works on it
						deadline_d      = due_time;
						res_d.event_res = EV_PROGRESS;
					end else begin
						pending_d   = 1'b0;
						done_cmd_d  = item_s1.command;
						done_p1_d   = pending_p1_q;
						done_time_d = item_s1.now_ms;
						if (item_s1.ack_result == ACK_ACCEPTED) begin
							reject_d        = 1'b0;
							res_d.event_res = EV_ACCEPTED;
						end else begin
							reject_d        = 1'b1;
							res_d.event_res = EV_REJECTED;
						end
					end
				end
			end
			FN_TICK: begin
				if (pending_q && (item_s1.now_ms >= deadline_q)) begin
					if ((retries_q < retry_limit_q) && item_s1.queue_room) begin
						retries_d  = retries_q + 4'd1;
						deadline_d = due_time;
						res_d.send_valid   = 1'b1;
						res_d.send_command = pending_cmd_q;
						res_d.send_param1  = pending_p1_q;
						res_d.event_res    = EV_RESENT;
					end else begin
						expired_cmd_d   = pending_cmd_q;
						pending_d       = 1'b0;
						timeout_d       = 1'b1;
						res_d.event_res = EV_TIMEOUT;
					end
				end
			end
			FN_CANCEL: begin
				if (pending_q) begin
					pending_d       = 1'b0;
					res_d.event_res = EV_CANCELLED;
				end
			end
			default: ;
		endcase

		res_d.retry_count    = retries_d;
		res_d.pending_flag   = pending_d;
		res_d.rejected_flag  = reject_d;
		res_d.timed_out_flag = timeout_d;
		res_d.last_ack_cmd   = ack_cmd_d;
		res_d.last_ack_code  = ack_code_d;
	end

	// tracker state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= 1'b0;
			pending_cmd_q <= '0;
			pending_p1_q  <= '0;
			deadline_q    <= '0;
			retries_q     <= '0;
			done_cmd_q    <= '0;
			done_p1_q     <= '0;
			done_time_q   <= '0;
			expired_cmd_q <= '0;
			ack_cmd_q     <= '0;
			ack_code_q    <= '0;
			reject_q      <= 1'b0;
			timeout_q     <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				pending_q     <= pending_d;
				pending_cmd_q <= pending_cmd_d;
				pending_p1_q  <= pending_p1_d;
				deadline_q    <= deadline_d;
				retries_q     <= retries_d;
				done_cmd_q    <= done_cmd_d;
				done_p1_q     <= done_p1_d;
				done_time_q   <= done_time_d;
				expired_cmd_q <= expired_cmd_d;
				ack_cmd_q     <= ack_cmd_d;
				ack_code_q    <= ack_code_d;
				reject_q      <= reject_d;
				timeout_q     <= timeout_d;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/cart_checker.sv
// Port-level checks for the command acknowledge and retry tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cart_checker
	import cart_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire result_t     res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	a_send_codes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.send_valid |->
			(res.event_res == EV_SENT) || (res.event_res == EV_RESENT))
		else $error("frame sent on an event that carries none");

	a_quiet_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.send_valid |->
			(res.send_command == 16'd0) && (res.send_param1 == 32'd0))
		else $error("frame fields not cleared without a send");

	a_sent_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.event_res == EV_SENT) |->
			res.pending_flag && (res.retry_count == 4'd0) &&
			!res.rejected_flag && !res.timed_out_flag)
		else $error("new command does not show a fresh pending state");

	a_timeout_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.event_res == EV_TIMEOUT) |->
			!res.pending_flag && res.timed_out_flag)
		else $error("timeout does not drop the pending command");

endmodule

bind command_ack_retry_tracker cart_checker u_cart_checker (.*);
`default_nettype wire
